/* hw/rtl/hms_pkg.sv */
package hms_pkg;

    // Default grid and fixed-point shape
    localparam int MAP_WIDTH_DEF  = 64;
    localparam int MAP_HEIGHT_DEF = 64;
    localparam int FRAC_BITS_DEF  = 8;

    // Sample store
    localparam int STORE_DEPTH = 4096;
    localparam int ADDR_W      = 12;
    localparam int SAMPLE_W    = 8;

    // Field widths
    localparam int QUERY_W  = 19;
    localparam int HEIGHT_W = 16;
    localparam int SCALE_W  = 8;
    localparam int CELL_W   = 5;

    // Stream layout: input tdata holds sample_index, sample_byte, query_x, query_z
    localparam int S_TDATA_W = 64;
    localparam int IDX_LSB   = 0;
    localparam int BYTE_LSB  = 12;
    localparam int QX_LSB    = 20;
    localparam int QZ_LSB    = 39;
    localparam int M_TDATA_W = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [SCALE_W-1:0] HEIGHT_SCALE_RST = 8'd15;
    localparam logic [CELL_W-1:0]  CELL_SIZE_RST    = 5'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEIGHT_SCALE = 1'b0,
        CFG_CELL_SIZE    = 1'b1
    } cfg_idx_t;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_QUERY = 1'b1
    } func_t;

    // One access to the sample store: write and read share the address
    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   addr;
        logic [SAMPLE_W-1:0] wdata;
    } store_req_t;

endpackage

/* hw/rtl/heightmap_height_sampler_top.sv */
// Height sampler over a 4096-entry store of raw 8-bit terrain samples.
// Write item: stored when taken; writes may follow each other back to back.
// Query: control states around an 11-bit cell divide and a 17-bit scaling divide; ends early
// with out_of_range when the position lies before the grid or past its last cell.
// One query at a time: no item is taken until a query's result has been handed to the output.
// Reset: sync, active low; registers to defaults, store swept to zero, s_tready low meanwhile.
module heightmap_height_sampler_top #(
    parameter int MAP_WIDTH  = hms_pkg::MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT = hms_pkg::MAP_HEIGHT_DEF,
    parameter int FRAC_BITS  = hms_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [hms_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [hms_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // sample_index[11:0], sample_byte[19:12], query_x[38:20], query_z[57:39], zeros above
    input  logic [hms_pkg::S_TDATA_W-1:0]   s_tdata,
    // func[0]
    input  logic [0:0]                      s_tuser,
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // height[15:0]
    output logic [hms_pkg::M_TDATA_W-1:0]   m_tdata,
    // out_of_range[0]
    output logic [0:0]                      m_tuser
);
    import hms_pkg::*;

    localparam int MAXD    = (MAP_WIDTH > MAP_HEIGHT) ? MAP_WIDTH : MAP_HEIGHT;
    localparam int MDW     = $clog2(MAXD);
    localparam int SPAN_W  = MDW + CELL_W;
    localparam int HW_BITS = SPAN_W + FRAC_BITS - 1;
    localparam int POS_W   = ((QUERY_W > HW_BITS + 1) ? QUERY_W : HW_BITS + 1) + 1;
    localparam int PI_W    = POS_W - 1 - FRAC_BITS;
    localparam int QQ_W    = CELL_W + FRAC_BITS;
    localparam int CQ_W    = SAMPLE_W + CELL_W;
    localparam int N_W     = CQ_W + FRAC_BITS;
    localparam int ACC_W   = QQ_W + SAMPLE_W + 3;
    localparam int PROD_W  = QQ_W + SAMPLE_W + 2;
    localparam int HS_W    = N_W + SCALE_W;
    localparam int DEN_W   = N_W;
    localparam int HNUM_W  = HS_W + FRAC_BITS + 1;
    localparam int HQUO_W  = ((SAMPLE_W + FRAC_BITS > HEIGHT_W) ?
                              SAMPLE_W + FRAC_BITS : HEIGHT_W) + 1;
    localparam logic [2:0] RD_LAST = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HALF,
        S_POS,
        S_PCHK,
        S_DIVP,
        S_BOUND,
        S_READ,
        S_TRI,
        S_MUL1,
        S_MUL2,
        S_SCALE,
        S_HSTART,
        S_HDIV,
        S_DONE
    } state_t;

    // ---------------------------------------------------------------- registers
    state_t                     state_reg;
    logic [SCALE_W-1:0]         height_scale_reg;
    logic [CELL_W-1:0]          cell_size_reg;

    logic signed [QUERY_W-1:0]  qx_reg;
    logic signed [QUERY_W-1:0]  qz_reg;
    logic [CELL_W-1:0]          q_reg;
    logic [SCALE_W-1:0]         hs_reg;
    logic [HW_BITS-1:0]         half_w_reg;
    logic [HW_BITS-1:0]         half_d_reg;
    logic signed [POS_W-1:0]    pos_x_reg;
    logic signed [POS_W-1:0]    pos_z_reg;
    logic [PI_W-1:0]            col_reg;
    logic [PI_W-1:0]            row_reg;
    logic [QQ_W-1:0]            rs_reg;
    logic [QQ_W-1:0]            rt_reg;
    logic [ADDR_W-1:0]          base_reg;
    logic [2:0]                 rd_cnt_reg;
    logic [SAMPLE_W-1:0]        samp_reg [4];
    logic signed [ACC_W-1:0]    acc_reg;
    logic [QQ_W-1:0]            mul1_reg;
    logic [QQ_W-1:0]            mul2_reg;
    logic signed [SAMPLE_W:0]   dif1_reg;
    logic signed [SAMPLE_W:0]   dif2_reg;
    logic [HS_W-1:0]            hs_prod_reg;
    logic [DEN_W-1:0]           den_reg;
    logic [HEIGHT_W-1:0]        res_height_reg;
    logic                       res_oor_reg;
    logic                       m_valid_reg;
    logic [HEIGHT_W-1:0]        m_data_reg;
    logic                       m_oor_reg;

    // ---------------------------------------------------------------- datapath
    logic                       clearing;
    logic [SAMPLE_W-1:0]        store_rdata;
    store_req_t                 store_req;
    logic                       in_take;
    func_t                      in_func;

    logic [CELL_W-1:0]          q_eff;
    logic [SPAN_W-1:0]          span_w;
    logic [SPAN_W-1:0]          span_d;
    logic signed [POS_W-1:0]    pos_x_next;
    logic signed [POS_W-1:0]    pos_z_next;
    logic                       pos_neg;

    logic                       pdiv_start;
    logic                       pdx_done;
    logic                       pdz_done;
    logic [PI_W-1:0]            pdx_quo;
    logic [PI_W-1:0]            pdz_quo;
    logic [CELL_W-1:0]          pdx_rem;
    logic [CELL_W-1:0]          pdz_rem;

    logic                       off_grid;
    logic [2*PI_W-1:0]          base_full;
    logic [ADDR_W-1:0]          rd_off;
    logic [1:0]                 rd_idx;

    logic [QQ_W-1:0]            qq;
    logic                       lower_tri;
    logic [SAMPLE_W-1:0]        corner;
    logic [CQ_W-1:0]            corner_q;
    logic signed [SAMPLE_W:0]   d_ba;
    logic signed [SAMPLE_W:0]   d_ca;
    logic signed [SAMPLE_W:0]   d_cd;
    logic signed [SAMPLE_W:0]   d_bd;

    logic [QQ_W-1:0]            mul_a;
    logic signed [SAMPLE_W:0]   mul_b;
    logic signed [PROD_W-1:0]   mul_p;

    logic [N_W-1:0]             n_clamp;
    logic [CQ_W-1:0]            q255;
    logic [HNUM_W-1:0]          hnum;
    logic                       hdiv_start;
    logic                       hdiv_done;
    logic [HQUO_W-1:0]          hdiv_quo;
    logic [HEIGHT_W-1:0]        height_sat;

    assign in_func = func_t'(s_tuser[0]);
    assign s_tready = (state_reg == S_IDLE) && !clearing;
    assign in_take  = s_tvalid && s_tready;

    // Store access: writes from the input channel, corner reads while sampling
    assign rd_off = (rd_cnt_reg[1] ? ADDR_W'(MAP_WIDTH) : '0) + ADDR_W'(rd_cnt_reg[0]);
    assign rd_idx = 2'(rd_cnt_reg - 3'd1);
    always_comb begin
        store_req.we    = in_take && (in_func == FUNC_WRITE);
        store_req.wdata = s_tdata[BYTE_LSB +: SAMPLE_W];
        store_req.addr  = (state_reg == S_READ) ? base_reg + rd_off
                                                : s_tdata[IDX_LSB +: ADDR_W];
    end

    hms_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (store_req),
        .rdata    (store_rdata),
        .clearing (clearing)
    );

    // Grid centring offsets and recentred position
    assign q_eff  = (cell_size_reg == '0) ? CELL_W'(1) : cell_size_reg;
    assign span_w = SPAN_W'(MAP_WIDTH - 1) * SPAN_W'(q_reg);
    assign span_d = SPAN_W'(MAP_HEIGHT - 1) * SPAN_W'(q_reg);
    assign pos_x_next = POS_W'(qx_reg) + POS_W'($signed({1'b0, half_w_reg}));
    assign pos_z_next = POS_W'($signed({1'b0, half_d_reg})) - POS_W'(qz_reg);
    assign pos_neg    = pos_x_reg[POS_W-1] || pos_z_reg[POS_W-1];

    // Cell and in-cell remainder, x and z side by side
    assign pdiv_start = (state_reg == S_PCHK) && !pos_neg;

    hms_div #(.NUM_W(PI_W + 1), .DEN_W(CELL_W), .QUO_W(PI_W)) u_div_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (pdiv_start),
        .num     ({1'b0, pos_x_reg[POS_W-2:FRAC_BITS]}),
        .den     (q_reg),
        .done    (pdx_done),
        .quo     (pdx_quo),
        .rem     (pdx_rem)
    );

    hms_div #(.NUM_W(PI_W + 1), .DEN_W(CELL_W), .QUO_W(PI_W)) u_div_z (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (pdiv_start),
        .num     ({1'b0, pos_z_reg[POS_W-2:FRAC_BITS]}),
        .den     (q_reg),
        .done    (pdz_done),
        .quo     (pdz_quo),
        .rem     (pdz_rem)
    );

    // Bounds check and row-major index of the cell's first corner
    assign off_grid  = (col_reg > PI_W'(MAP_WIDTH - 2)) || (row_reg > PI_W'(MAP_HEIGHT - 2));
    assign base_full = (2*PI_W)'(row_reg) * (2*PI_W)'(MAP_WIDTH) + (2*PI_W)'(col_reg);

    // Triangle choice and corner differences
    assign qq        = {q_reg, {FRAC_BITS{1'b0}}};
    assign lower_tri = ({1'b0, rs_reg} + {1'b0, rt_reg}) <= {1'b0, qq};
    assign corner    = lower_tri ? samp_reg[0] : samp_reg[3];
    assign corner_q  = CQ_W'(corner) * CQ_W'(q_reg);
    assign d_ba = $signed({1'b0, samp_reg[1]}) - $signed({1'b0, samp_reg[0]});
    assign d_ca = $signed({1'b0, samp_reg[2]}) - $signed({1'b0, samp_reg[0]});
    assign d_cd = $signed({1'b0, samp_reg[2]}) - $signed({1'b0, samp_reg[3]});
    assign d_bd = $signed({1'b0, samp_reg[1]}) - $signed({1'b0, samp_reg[3]});

    // One multiplier, used for both weighted differences
    assign mul_a = (state_reg == S_MUL1) ? mul1_reg : mul2_reg;
    assign mul_b = (state_reg == S_MUL1) ? dif1_reg : dif2_reg;
    assign mul_p = $signed({1'b0, mul_a}) * mul_b;

    // Scaling: height = round(n * scale * 2^F / (qq * 255))
    assign n_clamp = acc_reg[ACC_W-1] ? '0 : acc_reg[N_W-1:0];
    assign q255    = CQ_W'(q_reg) * CQ_W'(255);
    assign hnum    = {1'b0, hs_prod_reg, {FRAC_BITS{1'b0}}} + HNUM_W'(den_reg >> 1);
    assign hdiv_start = (state_reg == S_HSTART);

    hms_div #(.NUM_W(HNUM_W), .DEN_W(DEN_W), .QUO_W(HQUO_W)) u_div_h (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hdiv_start),
        .num     (hnum),
        .den     (den_reg),
        .done    (hdiv_done),
        .quo     (hdiv_quo),
        .rem     ()
    );

    assign height_sat = (|hdiv_quo[HQUO_W-1:HEIGHT_W]) ? '1 : hdiv_quo[HEIGHT_W-1:0];

    // ---------------------------------------------------------------- configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_scale_reg <= HEIGHT_SCALE_RST;
            cell_size_reg    <= CELL_SIZE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_HEIGHT_SCALE: height_scale_reg <= cfg_wdata[SCALE_W-1:0];
                CFG_CELL_SIZE:    cell_size_reg    <= cfg_wdata[CELL_W-1:0];
            endcase
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            rd_cnt_reg  <= '0;
        end else begin
            // drop the result once taken, unless the hand-over state reloads it
            if (m_valid_reg && m_tready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (in_take && (in_func == FUNC_QUERY)) begin
                        qx_reg    <= s_tdata[QX_LSB +: QUERY_W];
                        qz_reg    <= s_tdata[QZ_LSB +: QUERY_W];
                        q_reg     <= q_eff;
                        hs_reg    <= height_scale_reg;
                        state_reg <= S_HALF;
                    end
                end
                S_HALF: begin
                    half_w_reg <= {span_w, {(FRAC_BITS-1){1'b0}}};
                    half_d_reg <= {span_d, {(FRAC_BITS-1){1'b0}}};
                    state_reg  <= S_POS;
                end
                S_POS: begin
                    pos_x_reg <= pos_x_next;
                    pos_z_reg <= pos_z_next;
                    state_reg <= S_PCHK;
                end
                S_PCHK: begin
                    if (pos_neg) begin
                        res_height_reg <= '0;
                        res_oor_reg    <= 1'b1;
                        state_reg      <= S_DONE;
                    end else begin
                        state_reg <= S_DIVP;
                    end
                end
                S_DIVP: begin
                    if (pdx_done && pdz_done) begin
                        col_reg   <= pdx_quo;
                        row_reg   <= pdz_quo;
                        rs_reg    <= {pdx_rem, pos_x_reg[FRAC_BITS-1:0]};
                        rt_reg    <= {pdz_rem, pos_z_reg[FRAC_BITS-1:0]};
                        state_reg <= S_BOUND;
                    end
                end
                S_BOUND: begin
                    if (off_grid) begin
                        res_height_reg <= '0;
                        res_oor_reg    <= 1'b1;
                        state_reg      <= S_DONE;
                    end else begin
                        base_reg   <= base_full[ADDR_W-1:0];
                        rd_cnt_reg <= '0;
                        state_reg  <= S_READ;
                    end
                end
                S_READ: begin
                    // corners arrive in the cycle after their address
                    if (rd_cnt_reg != '0) begin
                        samp_reg[rd_idx] <= store_rdata;
                    end
                    if (rd_cnt_reg == RD_LAST) begin
                        state_reg <= S_TRI;
                    end else begin
                        rd_cnt_reg <= rd_cnt_reg + 3'd1;
                    end
                end
                S_TRI: begin
                    acc_reg <= ACC_W'($signed({1'b0, corner_q, {FRAC_BITS{1'b0}}}));
                    if (lower_tri) begin
                        mul1_reg <= rs_reg;
                        dif1_reg <= d_ba;
                        mul2_reg <= rt_reg;
                        dif2_reg <= d_ca;
                    end else begin
                        mul1_reg <= qq - rs_reg;
                        dif1_reg <= d_cd;
                        mul2_reg <= qq - rt_reg;
                        dif2_reg <= d_bd;
                    end
                    state_reg <= S_MUL1;
                end
                S_MUL1: begin
                    acc_reg   <= acc_reg + ACC_W'(mul_p);
                    state_reg <= S_MUL2;
                end
                S_MUL2: begin
                    acc_reg   <= acc_reg + ACC_W'(mul_p);
                    state_reg <= S_SCALE;
                end
                S_SCALE: begin
                    hs_prod_reg <= HS_W'(n_clamp) * HS_W'(hs_reg);
                    den_reg     <= {q255, {FRAC_BITS{1'b0}}};
                    state_reg   <= S_HSTART;
                end
                S_HSTART: begin
                    state_reg <= S_HDIV;
                end
                S_HDIV: begin
                    if (hdiv_done) begin
                        res_height_reg <= height_sat;
                        res_oor_reg    <= 1'b0;
                        state_reg      <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= res_height_reg;
                        m_oor_reg   <= res_oor_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_oor_reg;

    // ---------------------------------------------------------------- checks
    a_no_take_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s_tready)
        else $error("item taken during store sweep");

    a_oor_height_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_oor_reg) |-> (m_data_reg == '0))
        else $error("out-of-range result carries a height");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result loaded outside the hand-over state");

    a_hdiv_when_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        hdiv_done |-> (state_reg == S_HDIV))
        else $error("scaling divide finished while not awaited");

endmodule

/* hw/rtl/hms_div.sv */
module hms_div #(
    parameter int NUM_W = 12,
    parameter int DEN_W = 5,
    parameter int QUO_W = 11
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [QUO_W-1:0] quo,
    output logic [DEN_W-1:0] rem
);
    // Restoring divider, one quotient bit per cycle.
    // The caller guarantees num >> QUO_W < den.
    localparam int CNT_W = $clog2(QUO_W + 1);
    localparam int HI_W  = NUM_W - QUO_W;

    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [HI_W+DEN_W-1:0] hi_ext;
    logic [DEN_W+1:0]      trial;
    logic                  ge;

    assign hi_ext = {{DEN_W{1'b0}}, num[NUM_W-1:QUO_W]};
    assign trial  = {1'b0, rem_reg, quo_reg[QUO_W-1]} - {2'b00, den_reg};
    assign ge     = !trial[DEN_W+1];

    // Step the partial remainder and shift in quotient bits
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= hi_ext[DEN_W-1:0];
            quo_reg <= num[QUO_W-1:0];
            den_reg <= den;
        end else if (busy_reg) begin
            if (ge) begin
                rem_reg <= trial[DEN_W-1:0];
            end else begin
                rem_reg <= {rem_reg[DEN_W-2:0], quo_reg[QUO_W-1]};
            end
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    // Count iterations and pulse done on the last one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUO_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider finished without running");

endmodule

/* hw/rtl/hms_store.sv */
module hms_store (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  hms_pkg::store_req_t           req,
    output logic [hms_pkg::SAMPLE_W-1:0]  rdata,
    output logic                          clearing
);
    import hms_pkg::*;

    logic [SAMPLE_W-1:0] mem [STORE_DEPTH];
    logic [SAMPLE_W-1:0] rdata_reg;
    logic [ADDR_W-1:0]   clr_cnt_reg;
    logic                clearing_reg;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [SAMPLE_W-1:0] wr_data;

    // Sweep the store to zero after reset, one entry a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clearing_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == '1) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    assign wr_en   = clearing_reg || req.we;
    assign wr_addr = clearing_reg ? clr_cnt_reg : req.addr;
    assign wr_data = clearing_reg ? '0 : req.wdata;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[req.addr];
    end

    assign rdata    = rdata_reg;
    assign clearing = clearing_reg;

    a_sweep_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(clearing_reg) |-> $past(clr_cnt_reg) == '1)
        else $error("store sweep ended early");

endmodule

/* sim/tb_top.sv */
module tb_top;
    import hms_pkg::*;

    localparam int MAP_W         = MAP_WIDTH_DEF;
    localparam int MAP_H         = MAP_HEIGHT_DEF;
    localparam int FRAC          = FRAC_BITS_DEF;
    localparam int SETTLE_CYCLES = 100;
    localparam int PHASE_ITEMS   = 140;

    typedef struct {
        func_t                     func;
        logic [ADDR_W-1:0]         index;
        logic [SAMPLE_W-1:0]       sample_val;
        logic signed [QUERY_W-1:0] qx;
        logic signed [QUERY_W-1:0] qz;
    } terrain_item_t;

    typedef struct {
        logic [HEIGHT_W-1:0] height;
        logic                out_of_range;
    } height_res_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [0:0]            m_tuser;

    // Shadow of the block state
    logic [SAMPLE_W-1:0] terrain_mem [STORE_DEPTH];
    logic [SCALE_W-1:0]  scale_reg = HEIGHT_SCALE_RST;
    logic [CELL_W-1:0]   cell_reg  = CELL_SIZE_RST;

    terrain_item_t queued_items[$];
    height_res_t   expected_heights[$];
    terrain_item_t live_item;

    int src_idle_pct    = 0;
    int sink_stall_pct  = 0;
    int items_queued    = 0;
    int items_accepted  = 0;
    int writes_accepted = 0;
    int heights_checked = 0;
    int off_grid_seen   = 0;
    int settings_used   = 1;
    int mismatch_count  = 0;

    always #6 aclk = ~aclk;

    heightmap_height_sampler_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        for (int i = 0; i < STORE_DEPTH; i++) terrain_mem[i] = '0;
    end

    // Cell pitch in fixed point; a cell size of zero counts as one
    function automatic longint cell_quantum();
        longint cs;
        cs = (cell_reg == 0) ? 1 : longint'(cell_reg);
        return cs << FRAC;
    endfunction

    // Interpolated, scaled height at a world position
    function automatic height_res_t sample_terrain(logic signed [QUERY_W-1:0] qx,
                                                   logic signed [QUERY_W-1:0] qz);
        longint qq, xx, zz, col, row, rs, rt, a, b, c, d, n;
        longint unsigned den, num, h;
        height_res_t res;
        res.height       = '0;
        res.out_of_range = 1'b1;
        qq = cell_quantum();
        xx = qx + ((MAP_W - 1) * qq) / 2;
        zz = ((MAP_H - 1) * qq) / 2 - qz;
        if (xx < 0 || zz < 0) return res;
        col = xx / qq;
        row = zz / qq;
        if (col > MAP_W - 2 || row > MAP_H - 2) return res;
        rs = xx - col * qq;
        rt = zz - row * qq;
        a = terrain_mem[int'((row * MAP_W + col) & (STORE_DEPTH - 1))];
        b = terrain_mem[int'((row * MAP_W + col + 1) & (STORE_DEPTH - 1))];
        c = terrain_mem[int'(((row + 1) * MAP_W + col) & (STORE_DEPTH - 1))];
        d = terrain_mem[int'(((row + 1) * MAP_W + col + 1) & (STORE_DEPTH - 1))];
        // Lower triangle when s+t <= 1, upper otherwise
        if (rs + rt <= qq)
            n = a * qq + rs * (b - a) + rt * (c - a);
        else
            n = d * qq + (qq - rs) * (c - d) + (qq - rt) * (b - d);
        if (n < 0) n = 0;
        den = qq * 255;
        num = longint'(n) * longint'(scale_reg);
        num = (num << FRAC) + den / 2;
        h = num / den;
        if (h > 65535) h = 65535;
        res.height       = h[HEIGHT_W-1:0];
        res.out_of_range = 1'b0;
        return res;
    endfunction

    // Update the shadow state for an accepted item
    function automatic void accept_item(terrain_item_t it);
        items_accepted++;
        if (it.func == FUNC_WRITE) begin
            terrain_mem[it.index] = it.sample_val;
            writes_accepted++;
        end else begin
            expected_heights.push_back(sample_terrain(it.qx, it.qz));
        end
    endfunction

    // Driver: present queued items, idling at random
    always @(posedge aclk) begin : driver
        terrain_item_t next_item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) accept_item(live_item);
            if (queued_items.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                next_item = queued_items.pop_front();
                live_item = next_item;
                s_tvalid <= 1'b1;
                s_tuser  <= next_item.func;
                s_tdata  <= {{(S_TDATA_W - QZ_LSB - QUERY_W){1'b0}}, next_item.qz,
                             next_item.qx, next_item.sample_val, next_item.index};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: stall at random, check each result against the oldest expectation
    always @(posedge aclk) begin : monitor
        height_res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_heights.size() == 0) begin
                    $error("unexpected result: height %0d out_of_range %0d",
                           m_tdata, m_tuser[0]);
                    mismatch_count++;
                end else begin
                    want = expected_heights.pop_front();
                    heights_checked++;
                    if (want.out_of_range) off_grid_seen++;
                    if (m_tdata !== want.height) begin
                        $error("height: expected %0d, got %0d", want.height, m_tdata);
                        mismatch_count++;
                    end
                    if (m_tuser[0] !== want.out_of_range) begin
                        $error("out_of_range: expected %0d, got %0d",
                               want.out_of_range, m_tuser[0]);
                        mismatch_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    function automatic void push_write(logic [ADDR_W-1:0] index, logic [SAMPLE_W-1:0] val);
        terrain_item_t it;
        it.func       = FUNC_WRITE;
        it.index      = index;
        it.sample_val = val;
        it.qx         = QUERY_W'($urandom);
        it.qz         = QUERY_W'($urandom);
        queued_items.push_back(it);
        items_queued++;
    endfunction

    function automatic void push_query(logic [QUERY_W-1:0] qx, logic [QUERY_W-1:0] qz);
        terrain_item_t it;
        it.func       = FUNC_QUERY;
        it.index      = ADDR_W'($urandom);
        it.sample_val = SAMPLE_W'($urandom);
        it.qx         = qx;
        it.qz         = qz;
        queued_items.push_back(it);
        items_queued++;
    endfunction

    // Query given in grid coordinates: x from the left edge, z from the top row
    function automatic void push_grid_query(longint x_abs, longint z_abs);
        longint qq, wx, wz;
        qq = cell_quantum();
        wx = x_abs - ((MAP_W - 1) * qq) / 2;
        wz = ((MAP_H - 1) * qq) / 2 - z_abs;
        push_query(wx[QUERY_W-1:0], wz[QUERY_W-1:0]);
    endfunction

    // Hold until every item is taken and every height returned, then let the block idle
    task automatic settle();
        while (items_accepted != items_queued || expected_heights.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write both registers on consecutive edges; upper data bits of cell_size are don't-care
    task automatic write_regs(logic [SCALE_W-1:0] scale, logic [CELL_W-1:0] cell_sz);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_HEIGHT_SCALE;
        cfg_wdata <= scale;
        @(posedge aclk);
        cfg_addr  <= CFG_CELL_SIZE;
        cfg_wdata <= {3'($urandom_range(7)), cell_sz};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        scale_reg = scale;
        cell_reg  = cell_sz;
        settings_used++;
    endtask

    // Random traffic focused on a small patch so writes feed the queries
    task automatic run_phase(int n_items);
        int     wr, wc, pick;
        longint qq, rs, rt;
        logic [ADDR_W-1:0] index;
        wr = $urandom_range(MAP_H - 9);
        wc = $urandom_range(MAP_W - 9);
        qq = cell_quantum();
        for (int i = 0; i < n_items; i++) begin
            // Pause mid-phase until the block has drained
            if (i == n_items / 2) settle();
            pick = $urandom_range(99);
            if (pick < 40) begin
                if ($urandom_range(4) != 0)
                    index = ADDR_W'((wr + $urandom_range(8)) * MAP_W + wc + $urandom_range(8));
                else
                    index = ADDR_W'($urandom);
                case ($urandom_range(5))
                    0:       push_write(index, 8'd0);
                    1:       push_write(index, 8'd255);
                    default: push_write(index, SAMPLE_W'($urandom));
                endcase
            end else if (pick < 88) begin
                rt = $urandom_range(int'(qq - 1));
                case ($urandom_range(3))
                    0:       rs = 0;
                    1:       rs = (rt == 0) ? qq - 1 : qq - rt;
                    default: rs = $urandom_range(int'(qq - 1));
                endcase
                if (pick < 75)
                    push_grid_query((wc + $urandom_range(7)) * qq + rs,
                                    (wr + $urandom_range(7)) * qq + rt);
                else
                    push_grid_query($urandom_range(MAP_W - 1) * qq + rs,
                                    $urandom_range(MAP_H - 1) * qq + rt);
            end else begin
                push_query(QUERY_W'($urandom), QUERY_W'($urandom));
            end
        end
    endtask

    initial begin
        logic [SCALE_W-1:0] scale;
        logic [CELL_W-1:0]  cell_sz;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at reset settings (cell pitch 256)
        src_idle_pct   = 25;
        sink_stall_pct = 25;
        push_grid_query(8064, 8064);
        push_write(12'd0, 8'd255);
        push_write(12'd1, 8'd128);
        push_write(12'd64, 8'd60);
        push_write(12'd65, 8'd200);
        push_write(12'd4095, 8'd255);
        push_write(12'd4030, 8'd17);
        push_write(12'd4031, 8'd250);
        push_write(12'd4094, 8'd3);
        push_grid_query(0, 0);
        push_grid_query(64, 64);
        push_grid_query(128, 128);
        push_grid_query(200, 150);
        push_grid_query(255, 255);
        push_grid_query(-1, 10);
        push_grid_query(10, -1);
        push_grid_query(63 * 256, 100);
        push_grid_query(100, 63 * 256);
        push_grid_query(62 * 256 + 100, 62 * 256 + 30);
        push_grid_query(62 * 256 + 255, 62 * 256 + 255);
        push_query(19'h40000, 19'h40000);
        push_query(19'h3FFFF, 19'h3FFFF);
        push_query(19'h40000, 19'h3FFFF);
        push_query(19'h7FFFF, 19'h00000);

        // Phases over register settings and idle patterns
        for (int p = 0; p < 8; p++) begin
            settle();
            case (p)
                0: begin scale = 8'd255; cell_sz = 5'd16; end
                1: begin scale = 8'd1;   cell_sz = 5'd1;  end
                2: begin scale = 8'd0;   cell_sz = 5'd7;  end
                3: begin scale = 8'd200; cell_sz = 5'd0;  end
                4: begin scale = 8'd255; cell_sz = 5'd31; end
                5: begin scale = 8'd128; cell_sz = 5'd3;  end
                6: begin
                    scale   = SCALE_W'($urandom_range(1, 255));
                    cell_sz = CELL_W'($urandom_range(1, 16));
                end
                default: begin
                    scale   = SCALE_W'($urandom);
                    cell_sz = CELL_W'($urandom);
                end
            endcase
            write_regs(scale, cell_sz);
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 58; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 58; end
                default: begin src_idle_pct = 25; sink_stall_pct = 25; end
            endcase
            run_phase(PHASE_ITEMS);
        end
        settle();

        $display("Covered %0d sample writes and %0d height queries (%0d off the grid)",
                 writes_accepted, heights_checked, off_grid_seen);
        $display("across %0d register settings with sender and receiver idling mixed in",
                 settings_used);
        if (mismatch_count == 0 && expected_heights.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Run limit
    initial begin
        #(12 * 800000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/hms_pkg.sv
hw/rtl/hms_div.sv
hw/rtl/hms_store.sv
hw/rtl/heightmap_height_sampler_top.sv
sim/tb_top.sv
